// ===== sv/acb_pkg.sv =====
// Shared types and constants for the Aho-Corasick automaton builder.
package acb_pkg;

  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int MAX_NODES_DEF     = 1024;
  localparam int KIND_W            = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_BUILD  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_TRANS  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS,
    ST_RD,
    ST_TRN,
    ST_B_ROOT_RD,
    ST_B_ROOT_WR,
    ST_B_POP,
    ST_B_QD,
    ST_B_LINK,
    ST_B_SYM_RD,
    ST_B_SYM_WR,
    ST_RESP
  } state_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

// ===== sv/acb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acb_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/aho_corasick_builder_top.sv =====
// Top level of the Aho-Corasick automaton builder.
// After reset the block sweeps all MAX_NODES*ALPHABET_SIZE table entries
// (26624 by default) before it takes its first item. An insert, read or
// transition item takes one table read, and an insert that adds a node writes
// back: the item is read in the idle state, worked in its own state, and its
// result is loaded in the response state, which waits while the output is
// stalled. A build item walks the root row (read and write per symbol) and then
// every node in the queue: it pops the node and fetches its link, then reads
// and writes each symbol in turn. One item is in work at a time; the next
// is taken once the result stands in the output register.
module aho_corasick_builder_top #(
  parameter int ALPHABET_SIZE = acb_pkg::ALPHABET_SIZE_DEF,
  parameter int MAX_NODES     = acb_pkg::MAX_NODES_DEF,
  localparam int SYM_W  = $clog2(ALPHABET_SIZE),
  localparam int NW     = $clog2(MAX_NODES),
  localparam int CW     = $clog2(MAX_NODES + 1),
  localparam int IN_W   = ((SYM_W + NW + 7) / 8) * 8,
  localparam int OUT_W  = ((NW + (NW + 1) + NW + CW + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [IN_W-1:0]             s_tdata,  // symbol, node_index
  input  logic [acb_pkg::KIND_W-1:0]  s_tuser,  // kind
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [OUT_W-1:0]            m_tdata,  // node_id, parent_node, link_node, nodes_used
  output logic                        m_tuser   // status
);
  import acb_pkg::*;

  localparam int T   = MAX_NODES * ALPHABET_SIZE;
  localparam int TAW = $clog2(T);

  state_t state, state_next;

  logic [TAW-1:0]   clr;
  logic [NW-1:0]    cursor;
  logic [CW-1:0]    total;
  logic [CW-1:0]    head, tail;
  logic [SYM_W-1:0] bs;
  logic [NW-1:0]    bn, blk;
  logic             it_last, sym_ok_r, idx_ok_r;
  logic [NW-1:0]    it_idx;
  logic [TAW-1:0]   slot_r;
  logic [NW-1:0]    res_node, res_link;
  logic [NW:0]      res_parent;
  logic             res_status;

  logic             accept;
  logic [SYM_W-1:0] in_sym;
  logic [NW-1:0]    in_idx;
  logic             in_sym_ok, in_idx_ok, full, bs_last;
  logic             ins_alloc, ins_full;
  logic [NW-1:0]    ins_node;

  logic             c_we, g_we, p_we, l_we, q_we;
  logic [TAW-1:0]   c_waddr, c_raddr, g_waddr, g_raddr;
  logic [NW-1:0]    c_wdata, c_rdata, g_wdata, g_rdata;
  logic [NW-1:0]    p_waddr, p_raddr, l_waddr, l_raddr, q_waddr, q_raddr;
  logic [NW:0]      p_wdata, p_rdata;
  logic [NW-1:0]    l_wdata, l_rdata, q_wdata, q_rdata;

  assign in_sym    = s_tdata[SYM_W-1:0];
  assign in_idx    = s_tdata[SYM_W +: NW];
  assign in_sym_ok = {1'b0, in_sym} < (SYM_W + 1)'(ALPHABET_SIZE);
  assign in_idx_ok = CW'(in_idx) < total;
  assign full      = total == CW'(MAX_NODES);
  assign bs_last   = bs == SYM_W'(ALPHABET_SIZE - 1);
  assign s_tready  = state == ST_IDLE;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    ins_alloc = sym_ok_r && (c_rdata == '0) && !full;
    ins_full  = sym_ok_r && (c_rdata == '0) && full;
    if (!sym_ok_r || ins_full) begin
      ins_node = cursor;
    end else if (ins_alloc) begin
      ins_node = total[NW-1:0];
    end else begin
      ins_node = c_rdata;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:     if (clr == TAW'(T - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_t'(s_tuser))
            KIND_INSERT: state_next = ST_INS;
            KIND_BUILD:  state_next = ST_B_ROOT_RD;
            KIND_READ:   state_next = ST_RD;
            KIND_TRANS:  state_next = ST_TRN;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_INS, ST_RD, ST_TRN: state_next = ST_RESP;
      ST_B_ROOT_RD: state_next = ST_B_ROOT_WR;
      ST_B_ROOT_WR: state_next = bs_last ? ST_B_POP : ST_B_ROOT_RD;
      ST_B_POP:     state_next = (head == tail) ? ST_RESP : ST_B_QD;
      ST_B_QD:      state_next = ST_B_LINK;
      ST_B_LINK:    state_next = ST_B_SYM_RD;
      ST_B_SYM_RD:  state_next = ST_B_SYM_WR;
      ST_B_SYM_WR:  state_next = bs_last ? ST_B_POP : ST_B_SYM_RD;
      ST_RESP:      if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:      state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
    g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr;
        g_we    = 1'b1;
        g_waddr = clr;
        if (clr < TAW'(MAX_NODES)) begin
          l_we    = 1'b1;
          l_waddr = clr[NW-1:0];
        end
      end
      ST_IDLE: begin
        if (in_sym_ok) begin
          c_raddr = TAW'(TAW'(cursor) * TAW'(ALPHABET_SIZE) + TAW'(in_sym));
        end
        if (in_sym_ok && in_idx_ok) begin
          g_raddr = TAW'(TAW'(in_idx) * TAW'(ALPHABET_SIZE) + TAW'(in_sym));
        end
        if (in_idx_ok) begin
          p_raddr = in_idx;
          l_raddr = in_idx;
        end
      end
      ST_INS: begin
        if (ins_alloc) begin
          c_we    = 1'b1;
          c_waddr = slot_r;
          c_wdata = total[NW-1:0];
          p_we    = 1'b1;
          p_waddr = total[NW-1:0];
          p_wdata = {1'b0, cursor};
          l_we    = 1'b1;
          l_waddr = total[NW-1:0];
        end
      end
      ST_B_ROOT_RD: c_raddr = TAW'(bs);
      ST_B_ROOT_WR: begin
        if (c_rdata != '0) begin
          g_we    = 1'b1;
          g_waddr = TAW'(bs);
          g_wdata = c_rdata;
          q_we    = 1'b1;
          q_waddr = tail[NW-1:0];
          q_wdata = c_rdata;
        end
      end
      ST_B_POP:     q_raddr = head[NW-1:0];
      ST_B_QD:      l_raddr = q_rdata;
      ST_B_SYM_RD: begin
        g_raddr = TAW'(TAW'(blk) * TAW'(ALPHABET_SIZE) + TAW'(bs));
        c_raddr = TAW'(TAW'(bn) * TAW'(ALPHABET_SIZE) + TAW'(bs));
      end
      ST_B_SYM_WR: begin
        g_we    = 1'b1;
        g_waddr = slot_r;
        g_wdata = (c_rdata != '0) ? c_rdata : g_rdata;
        if (c_rdata != '0) begin
          l_we    = 1'b1;
          l_waddr = c_rdata;
          l_wdata = g_rdata;
          q_we    = 1'b1;
          q_waddr = tail[NW-1:0];
          q_wdata = c_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr      <= '0;
      cursor   <= '0;
      total    <= CW'(1);
      head     <= '0;
      tail     <= '0;
      bs       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready && state != ST_RESP) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: clr <= TAW'(clr + TAW'(1));
        ST_IDLE: begin
          if (accept) begin
            it_last    <= s_tlast;
            it_idx     <= in_idx;
            sym_ok_r   <= in_sym_ok;
            idx_ok_r   <= in_idx_ok;
            slot_r     <= TAW'(TAW'(cursor) * TAW'(ALPHABET_SIZE) + TAW'(in_sym));
            res_node   <= '0;
            res_parent <= '0;
            res_link   <= '0;
            res_status <= STATUS_OK;
            bs         <= '0;
            head       <= '0;
            tail       <= '0;
          end
        end
        ST_INS: begin
          res_node   <= ins_node;
          res_status <= ins_full ? STATUS_FULL : STATUS_OK;
          cursor     <= it_last ? '0 : ins_node;
          if (ins_alloc) begin
            total <= CW'(total + CW'(1));
          end
        end
        ST_RD: begin
          if (idx_ok_r) begin
            res_parent <= (it_idx == '0) ? '1 : p_rdata;
            res_link   <= l_rdata;
          end
        end
        ST_TRN: begin
          if (idx_ok_r && sym_ok_r) begin
            res_node <= g_rdata;
          end
        end
        ST_B_ROOT_WR: begin
          if (c_rdata != '0) begin
            tail <= CW'(tail + CW'(1));
          end
          bs <= bs_last ? '0 : SYM_W'(bs + SYM_W'(1));
        end
        ST_B_POP: begin
          if (head != tail) begin
            head <= CW'(head + CW'(1));
          end
        end
        ST_B_QD:   bn <= q_rdata;
        ST_B_LINK: begin
          blk <= l_rdata;
          bs  <= '0;
        end
        ST_B_SYM_RD: slot_r <= TAW'(TAW'(bn) * TAW'(ALPHABET_SIZE) + TAW'(bs));
        ST_B_SYM_WR: begin
          if (c_rdata != '0) begin
            tail <= CW'(tail + CW'(1));
          end
          bs <= bs_last ? '0 : SYM_W'(bs + SYM_W'(1));
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({total, res_link, res_parent, res_node});
            m_tuser  <= res_status;
          end
        end
        default: begin
        end
      endcase
    end
  end

  acb_ram #(.W(NW), .D(T)) u_child (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  acb_ram #(.W(NW), .D(T)) u_goto (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  acb_ram #(.W(NW + 1), .D(MAX_NODES)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  acb_ram #(.W(NW), .D(MAX_NODES)) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  acb_ram #(.W(NW), .D(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

endmodule

// ===== sv/acb_checker.sv =====
// Port-level checks for the Aho-Corasick automaton builder.
module acb_checker #(
  parameter int ALPHABET_SIZE = acb_pkg::ALPHABET_SIZE_DEF,
  parameter int MAX_NODES     = acb_pkg::MAX_NODES_DEF,
  localparam int SYM_W  = $clog2(ALPHABET_SIZE),
  localparam int NW     = $clog2(MAX_NODES),
  localparam int CW     = $clog2(MAX_NODES + 1),
  localparam int IN_W   = ((SYM_W + NW + 7) / 8) * 8,
  localparam int OUT_W  = ((NW + (NW + 1) + NW + CW + 7) / 8) * 8
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [IN_W-1:0]            s_tdata,
  input logic [acb_pkg::KIND_W-1:0] s_tuser,
  input logic                       s_tlast,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [OUT_W-1:0]           m_tdata,
  input logic                       m_tuser
);
  import acb_pkg::*;

  localparam int USED_LO = 3 * NW + 1;

  logic [CW-1:0] used;
  assign used = m_tdata[USED_LO +: CW];

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser)
      && $stable(s_tlast))
    else $error("Input item changed while waiting.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Result changed while stalled.");

  a_sweep: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("Item taken during the table sweep.");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STATUS_FULL) |-> used == CW'(MAX_NODES))
    else $error("Store full reported with free nodes.");

  a_used: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (used != '0) && (used <= CW'(MAX_NODES)))
    else $error("Node count out of range.");

endmodule

bind aho_corasick_builder_top acb_checker #(
  .ALPHABET_SIZE(ALPHABET_SIZE),
  .MAX_NODES(MAX_NODES)
) u_acb_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the Aho-Corasick automaton builder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import acb_pkg::*;

  localparam int ALPHA = ALPHABET_SIZE_DEF;
  localparam int MAXN  = MAX_NODES_DEF;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] sym;
    logic       last;
    logic [9:0] idx;
  } op_item_t;

  typedef struct packed {
    logic [9:0]  node_id;
    logic [10:0] parent;
    logic [9:0]  link;
    logic [10:0] used;
    logic        status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic m_tuser;

  aho_corasick_builder_top DUT (.*);

  always #2 clk = ~clk;

  int unsigned child_tab [MAXN*ALPHA];
  int unsigned goto_tab [MAXN*ALPHA];
  int parent_of [MAXN];
  int unsigned link_of [MAXN];
  int unsigned used_cnt;
  int unsigned cursor;

  op_item_t pending_ops[$];
  answer_t expected_answers[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit stim_done = 0;

  function automatic void build_links();
    int unsigned fifo[$];
    int unsigned n, c, lk;
    for (int s = 0; s < ALPHA; s++) begin
      c = child_tab[s];
      if (c != 0) begin
        goto_tab[s] = c;
        fifo = {fifo, c};
      end
    end
    while (fifo.size() > 0) begin
      n = fifo.pop_front();
      lk = link_of[n];
      for (int s = 0; s < ALPHA; s++) goto_tab[n*ALPHA+s] = goto_tab[lk*ALPHA+s];
      for (int s = 0; s < ALPHA; s++) begin
        c = child_tab[n*ALPHA+s];
        if (c != 0) begin
          link_of[c] = goto_tab[n*ALPHA+s];
          goto_tab[n*ALPHA+s] = c;
          fifo = {fifo, c};
        end
      end
    end
  endfunction

  function automatic answer_t predict_answer(op_item_t it);
    answer_t a;
    int unsigned c;
    a = '0;
    case (kind_t'(it.kind))
      KIND_INSERT: begin
        if (it.sym < ALPHA) begin
          c = child_tab[cursor*ALPHA+it.sym];
          if (c == 0) begin
            if (used_cnt < MAXN) begin
              c = used_cnt;
              child_tab[cursor*ALPHA+it.sym] = c;
              parent_of[c] = cursor;
              link_of[c] = 0;
              used_cnt++;
              cursor = c;
            end else a.status = STATUS_FULL;
          end else cursor = c;
        end
        a.node_id = 10'(cursor);
        if (it.last) cursor = 0;
      end
      KIND_BUILD: build_links();
      KIND_READ: begin
        if (it.idx < used_cnt) begin
          a.parent = 11'(parent_of[it.idx]);
          a.link = 10'(link_of[it.idx]);
        end
      end
      default: begin
        if (it.idx < used_cnt && it.sym < ALPHA)
          a.node_id = 10'(goto_tab[it.idx*ALPHA+it.sym]);
      end
    endcase
    a.used = 11'(used_cnt);
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle) begin
        op_item_t it;
        it = pending_ops.pop_front();
        expected_answers = {expected_answers, predict_answer(it)};
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tlast <= it.last;
        s_tdata <= {1'b0, it.idx, it.sym};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result item %h", m_tdata);
          errors++;
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (m_tdata[9:0] !== e.node_id) begin
            $error("node_id expected %0d actual %0d", e.node_id, m_tdata[9:0]);
            errors++;
          end
          if (m_tdata[20:10] !== e.parent) begin
            $error("parent_node expected %0d actual %0d", $signed(e.parent),
                   $signed(m_tdata[20:10]));
            errors++;
          end
          if (m_tdata[30:21] !== e.link) begin
            $error("link_node expected %0d actual %0d", e.link, m_tdata[30:21]);
            errors++;
          end
          if (m_tdata[41:31] !== e.used) begin
            $error("nodes_used expected %0d actual %0d", e.used, m_tdata[41:31]);
            errors++;
          end
          if (m_tuser !== e.status) begin
            $error("status expected %0d actual %0d", e.status, m_tuser);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic op_item_t mk(kind_t k, int s, bit l, int i);
    op_item_t it;
    it.kind = k;
    it.sym = 5'(s);
    it.last = l;
    it.idx = 10'(i);
    return it;
  endfunction

  function automatic void add_op(op_item_t it);
    pending_ops = {pending_ops, it};
  endfunction

  function automatic void add_query(int hi);
    int r;
    r = $urandom_range(99);
    if (r < 45)
      add_op(mk(KIND_TRANS, $urandom_range(26), 0, $urandom_range(hi)));
    else if (r < 90)
      add_op(mk(KIND_READ, $urandom_range(31), 1'($urandom_range(1)),
                $urandom_range(hi)));
    else
      add_op(mk(KIND_TRANS, $urandom_range(31), 1'($urandom_range(1)),
                $urandom_range(1023)));
  endfunction

  task automatic drain();
    while (pending_ops.size() > 0 || expected_answers.size() > 0) @(posedge clk);
  endtask

  initial begin
    int plen, sym_hi;
    for (int i = 0; i < MAXN*ALPHA; i++) begin
      child_tab[i] = 0;
      goto_tab[i] = 0;
    end
    for (int i = 0; i < MAXN; i++) begin
      parent_of[i] = 0;
      link_of[i] = 0;
    end
    parent_of[0] = -1;
    used_cnt = 1;
    cursor = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add_op(mk(KIND_READ, 0, 0, 0));
    add_op(mk(KIND_TRANS, 0, 0, 0));
    add_op(mk(KIND_INSERT, 0, 0, 0));
    add_op(mk(KIND_INSERT, 25, 0, 1023));
    add_op(mk(KIND_INSERT, 31, 1, 0));
    add_op(mk(KIND_INSERT, 25, 0, 0));
    add_op(mk(KIND_BUILD, 0, 0, 0));
    add_op(mk(KIND_INSERT, 0, 1, 0));
    add_op(mk(KIND_INSERT, 25, 0, 0));
    add_op(mk(KIND_INSERT, 0, 1, 0));
    add_op(mk(KIND_BUILD, 31, 1, 1023));
    for (int n = 0; n < 5; n++) begin
      add_op(mk(KIND_READ, 0, 0, n));
      add_op(mk(KIND_TRANS, 25, 0, n));
    end
    add_op(mk(KIND_TRANS, 26, 0, 1));
    add_op(mk(KIND_TRANS, 0, 0, 1023));
    add_op(mk(KIND_READ, 31, 1, 1023));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 69; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 69; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      sym_hi = (ph < 4) ? 3 : 25;
      for (int p = 0; p < 20; p++) begin
        plen = $urandom_range(1, 8);
        for (int k = 0; k < plen; k++)
          add_op(mk(KIND_INSERT,
                    ($urandom_range(19) == 0) ? $urandom_range(26, 31)
                                              : $urandom_range(sym_hi),
                    k == plen - 1, $urandom_range(1023)));
        if ($urandom_range(9) == 0) add_op(mk(KIND_BUILD, 0, 0, 0));
      end
      add_op(mk(KIND_BUILD, $urandom_range(31), 1'($urandom_range(1)),
                $urandom_range(1023)));
      for (int q = 0; q < 35; q++) add_query(ph < 4 ? 200 : 1023);
      drain();
    end

    send_idle = 0;
    recv_stall = 0;
    while (used_cnt < MAXN || cursor != 0) begin
      for (int k = 0; k < 12; k++)
        add_op(mk(KIND_INSERT, $urandom_range(25), k == 11, 0));
      drain();
    end
    send_idle = 11;
    recv_stall = 11;
    for (int k = 0; k < 30; k++)
      add_op(mk(KIND_INSERT, $urandom_range(25), k % 6 == 5, 0));
    add_op(mk(KIND_BUILD, 0, 0, 0));
    for (int q = 0; q < 40; q++) add_query(1023);
    add_op(mk(KIND_READ, 0, 0, 1023));
    add_op(mk(KIND_TRANS, 25, 0, 1023));
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
